[sv/calendar_second_counter_top_defines.svh]
// Assertion macros shared by the calendar second counter RTL.
`ifndef CALENDAR_SECOND_COUNTER_TOP_DEFINES_SVH
`define CALENDAR_SECOND_COUNTER_TOP_DEFINES_SVH

// Plain property, checked on every rising edge outside reset.
`define CSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: when pre holds, post must hold in the same cycle.
`define CSC_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[sv/csc_pkg.sv]
// Types, constants and the month length function for the calendar counter.
package csc_pkg;

    localparam logic [7:0] YEAR_MAX_LOAD = 8'd99;
    localparam logic [7:0] YEAR_NO_PACK  = 8'd64;
    localparam logic [3:0] MONTH_LAST    = 4'd12;
    localparam logic [4:0] HOUR_LAST     = 5'd23;
    localparam logic [5:0] MINSEC_LAST   = 6'd59;
    localparam logic [3:0] MONTH_FEB     = 4'd2;
    localparam logic [31:0] PACKED_ALL_ONES = 32'hFFFF_FFFF;

    // Days per month, indexed by month; entries outside 1..12 unused.
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Input tdata, last field in the lowest bits.
    typedef struct packed {
        logic [5:0] pad;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
    } in_data_t;

    // Output tdata, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] packed_time;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [7:0]  year;
    } out_data_t;

    // Output tuser flags, highest bit first.
    typedef struct packed {
        logic day_rolled;
        logic load_rejected;
    } out_user_t;

    function automatic logic [4:0] days_in_month(logic [3:0] month, logic [7:0] year);
        logic [4:0] d;
        d = MONTH_LEN[month];
        if (month == MONTH_FEB && year[1:0] == 2'b00)
        begin
            d = 5'd29;
        end
        return d;
    endfunction

endpackage

[sv/calendar_second_counter_top.sv]
// Calendar second counter: tick and load items in, current date-time out.
//
// Usage
//   Slave stream (s_axis_*) carries one item per handshake. tuser selects the
//   kind: 0 advances the time by one second, 1 loads a new date-time from
//   tdata. A load is applied only if every field is in range (year 0..99,
//   month 1..12, day within that month, 23:59:59 at most); otherwise the
//   time is left as it was and the result flags the rejection.
//   Master stream (m_axis_*) gives exactly one result per item: the current
//   fields, the 32-bit packed time (all ones from year 64 on) and two flags.
// Pipeline and throughput
//   The input register takes the item, then the calendar update and packing
//   go into the result register. One item per cycle sustained while the
//   result is taken; the counter state is written in the same edge as the
//   result, so back-to-back items see each other's effect.
// Reset
//   rst_n low clears both pipeline stages and sets 2000-01-01 00:00:00.
// Stall
//   With m_axis_tready low the result holds and the input register fills;
//   s_axis_tready then drops until the result is taken.
module calendar_second_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[7:0], month[11:8], day[16:12], hours[21:17], minutes[27:22],
    // seconds[33:28], zero fill [39:34]
    input  logic [39:0] s_axis_tdata,
    // operation (0 tick, 1 load)
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cur_year[7:0], cur_month[11:8], cur_day[16:12], cur_hours[21:17],
    // cur_minutes[27:22], cur_seconds[33:28], packed_time[65:34], zeros [71:66]
    output logic [71:0] m_axis_tdata,
    // load_rejected[0], day_rolled[1]
    output logic [1:0]  m_axis_tuser
);

    `include "calendar_second_counter_top_defines.svh"

    // Input stage
    logic               in_valid_reg;
    csc_pkg::op_t       in_op_reg;
    csc_pkg::in_data_t  in_data_reg;

    // Calendar state
    logic [5:0] sec_reg,   sec_next;
    logic [5:0] min_reg,   min_next;
    logic [4:0] hour_reg,  hour_next;
    logic [4:0] day_reg,   day_next;
    logic [3:0] month_reg, month_next;
    logic [7:0] year_reg,  year_next;

    // Result stage
    logic               out_valid_reg;
    csc_pkg::out_data_t out_data_reg,  out_data_next;
    csc_pkg::out_user_t out_user_reg,  out_user_next;

    logic advance;
    logic load_ok;
    logic sec_last, min_last, hour_last, day_last, month_last, rolled;
    csc_pkg::in_data_t s_data;

    assign s_data        = csc_pkg::in_data_t'(s_axis_tdata);
    // Result register frees up when empty or when being taken this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Load validation
    assign load_ok = (in_data_reg.seconds <= csc_pkg::MINSEC_LAST)
                  && (in_data_reg.minutes <= csc_pkg::MINSEC_LAST)
                  && (in_data_reg.hours   <= csc_pkg::HOUR_LAST)
                  && (in_data_reg.year    <= csc_pkg::YEAR_MAX_LOAD)
                  && (in_data_reg.month   != 4'd0)
                  && (in_data_reg.month   <= csc_pkg::MONTH_LAST)
                  && (in_data_reg.day     != 5'd0)
                  && (in_data_reg.day <= csc_pkg::days_in_month(in_data_reg.month,
                                                                in_data_reg.year));

    // Carry chain for a tick
    assign sec_last   = sec_reg  >= csc_pkg::MINSEC_LAST;
    assign min_last   = min_reg  >= csc_pkg::MINSEC_LAST;
    assign hour_last  = hour_reg >= csc_pkg::HOUR_LAST;
    assign rolled     = sec_last && min_last && hour_last;
    assign day_last   = day_reg >= csc_pkg::days_in_month(month_reg, year_reg);
    assign month_last = month_reg >= csc_pkg::MONTH_LAST;

    always_comb
    begin
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        out_user_next = '0;
        case (in_op_reg)
            csc_pkg::OP_LOAD:
            begin
                if (load_ok)
                begin
                    sec_next   = in_data_reg.seconds;
                    min_next   = in_data_reg.minutes;
                    hour_next  = in_data_reg.hours;
                    day_next   = in_data_reg.day;
                    month_next = in_data_reg.month;
                    year_next  = in_data_reg.year;
                end
                else
                begin
                    out_user_next.load_rejected = 1'b1;
                end
            end
            default:
            begin
                sec_next = sec_last ? 6'd0 : sec_reg + 6'd1;
                if (sec_last)
                begin
                    min_next = min_last ? 6'd0 : min_reg + 6'd1;
                    if (min_last)
                    begin
                        hour_next = hour_last ? 5'd0 : hour_reg + 5'd1;
                    end
                end
                if (rolled)
                begin
                    out_user_next.day_rolled = 1'b1;
                    day_next = day_last ? 5'd1 : day_reg + 5'd1;
                    if (day_last)
                    begin
                        month_next = month_last ? 4'd1 : month_reg + 4'd1;
                        if (month_last)
                        begin
                            year_next = year_reg + 8'd1;
                        end
                    end
                end
            end
        endcase

        out_data_next.pad     = '0;
        out_data_next.year    = year_next;
        out_data_next.month   = month_next;
        out_data_next.day     = day_next;
        out_data_next.hours   = hour_next;
        out_data_next.minutes = min_next;
        out_data_next.seconds = sec_next;
        if (year_next >= csc_pkg::YEAR_NO_PACK)
        begin
            out_data_next.packed_time = csc_pkg::PACKED_ALL_ONES;
        end
        else
        begin
            out_data_next.packed_time = {year_next[5:0], month_next, day_next,
                                         hour_next, min_next, sec_next};
        end
    end

    // Control and calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    sec_reg   <= sec_next;
                    min_reg   <= min_next;
                    hour_reg  <= hour_next;
                    day_reg   <= day_next;
                    month_reg <= month_next;
                    year_reg  <= year_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= csc_pkg::op_t'(s_axis_tuser);
            in_data_reg <= s_data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // Checks
    `CSC_ASSERT_IMP(a_time_range, out_valid_reg,
        out_data_reg.seconds <= 6'd59 && out_data_reg.minutes <= 6'd59 &&
        out_data_reg.hours <= 5'd23, "result time of day out of range")
    `CSC_ASSERT(a_flags_exclusive,
        !(out_valid_reg && out_user_reg.load_rejected && out_user_reg.day_rolled),
        "rejected load and midnight roll flagged together")
    `CSC_ASSERT_IMP(a_packed_match, out_valid_reg && out_data_reg.year < 8'd64,
        out_data_reg.packed_time[31:26] == out_data_reg.year[5:0] &&
        out_data_reg.packed_time[5:0] == out_data_reg.seconds,
        "packed time disagrees with result fields")
    `CSC_ASSERT(a_date_state,
        month_reg != 4'd0 && month_reg <= 4'd12 && day_reg != 5'd0,
        "calendar state holds an impossible date")

endmodule

[tb/calendar_second_counter_top_tb.sv]
// Self-checking stream testbench for the calendar second counter.
module calendar_second_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Far above the slowest legal run: 950 items, each with a full sender
    // gap, a full receiver stall and the pipeline latency.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned ITEM_TARGET  = 950;
    localparam int unsigned DRAIN_CYCLES = 10;

    // One result as the block should report it.
    typedef struct {
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [31:0] packed_time;
        logic        load_rejected;
        logic        day_rolled;
    } clock_reading_t;

    // One item waiting to be sent.
    typedef struct {
        csc_pkg::op_t      op;
        csc_pkg::in_data_t data;
    } calendar_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    calendar_cmd_t  pending_cmds[$];
    clock_reading_t expected_readings[$];

    // Our own copy of the calendar, advanced as each item is accepted.
    logic [7:0] cal_year  = 8'd0;
    logic [3:0] cal_month = 4'd1;
    logic [4:0] cal_day   = 5'd1;
    logic [4:0] cal_hour  = 5'd0;
    logic [5:0] cal_min   = 6'd0;
    logic [5:0] cal_sec   = 6'd0;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned loads_taken = 0;
    int unsigned loads_refused = 0;
    int unsigned midnights = 0;
    int unsigned unpackable_years = 0;
    int unsigned results_seen = 0;

    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b1;

    calendar_second_counter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Days in a month; February gets 29 whenever the low two year bits are
    // clear, which also holds for years past 99.
    function automatic logic [4:0] month_days(logic [3:0] month, logic [7:0] year);
        case (month)
            4'd2:                    return (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    // Apply one item to the calendar copy and return the reading it causes.
    function automatic clock_reading_t step_calendar(csc_pkg::op_t op, csc_pkg::in_data_t d);
        clock_reading_t r;
        bit             fits;
        r.load_rejected = 1'b0;
        r.day_rolled    = 1'b0;
        if (op == csc_pkg::OP_LOAD)
        begin
            fits = d.seconds <= 6'd59 && d.minutes <= 6'd59 && d.hours <= 5'd23 &&
                   d.year <= 8'd99 && d.month >= 4'd1 && d.month <= 4'd12 &&
                   d.day >= 5'd1 && d.day <= month_days(d.month, d.year);
            if (fits)
            begin
                cal_year  = d.year;
                cal_month = d.month;
                cal_day   = d.day;
                cal_hour  = d.hours;
                cal_min   = d.minutes;
                cal_sec   = d.seconds;
                loads_taken++;
            end
            else
            begin
                // state left alone, flag raised
                r.load_rejected = 1'b1;
                loads_refused++;
            end
        end
        else
        begin
            ticks_sent++;
            if (cal_sec == 6'd59)
            begin
                cal_sec = 6'd0;
                if (cal_min == 6'd59)
                begin
                    cal_min = 6'd0;
                    if (cal_hour == 5'd23)
                    begin
                        cal_hour = 5'd0;
                        r.day_rolled = 1'b1;
                    end
                    else
                    begin
                        cal_hour++;
                    end
                end
                else
                begin
                    cal_min++;
                end
            end
            else
            begin
                cal_sec++;
            end
            if (r.day_rolled)
            begin
                midnights++;
                if (cal_day >= month_days(cal_month, cal_year))
                begin
                    cal_day = 5'd1;
                    if (cal_month == 4'd12)
                    begin
                        cal_month = 4'd1;
                        cal_year  = cal_year + 8'd1;  // wraps at 255
                    end
                    else
                    begin
                        cal_month++;
                    end
                end
                else
                begin
                    cal_day++;
                end
            end
        end
        r.year    = cal_year;
        r.month   = cal_month;
        r.day     = cal_day;
        r.hours   = cal_hour;
        r.minutes = cal_min;
        r.seconds = cal_sec;
        if (cal_year >= 8'd64)
        begin
            r.packed_time = 32'hFFFF_FFFF;
            unpackable_years++;
        end
        else
        begin
            r.packed_time = {cal_year[5:0], cal_month, cal_day, cal_hour, cal_min, cal_sec};
        end
        return r;
    endfunction

    function automatic csc_pkg::in_data_t date_fields(logic [7:0] y, logic [3:0] mo,
                                                      logic [4:0] d, logic [4:0] h,
                                                      logic [5:0] mi, logic [5:0] s);
        csc_pkg::in_data_t f;
        f.pad     = '0;
        f.year    = y;
        f.month   = mo;
        f.day     = d;
        f.hours   = h;
        f.minutes = mi;
        f.seconds = s;
        return f;
    endfunction

    function automatic void queue_load(csc_pkg::in_data_t d);
        calendar_cmd_t c;
        c.op   = csc_pkg::OP_LOAD;
        c.data = d;
        pending_cmds.push_back(c);
    endfunction

    // Tick items carry random payload; the block must ignore it.
    function automatic void queue_ticks(int unsigned n);
        calendar_cmd_t c;
        for (int unsigned i = 0; i < n; i++)
        begin
            c.op       = csc_pkg::OP_TICK;
            c.data     = csc_pkg::in_data_t'(40'({$urandom, $urandom}));
            c.data.pad = '0;
            pending_cmds.push_back(c);
        end
    endfunction

    // A valid date-time, biased towards the end of a minute, hour, day,
    // month and year so that short tick runs reach the carries.
    function automatic csc_pkg::in_data_t near_boundary();
        logic [7:0] y;
        logic [3:0] mo;
        logic [4:0] last;
        y    = 8'($urandom_range(0, 99));
        mo   = ($urandom_range(0, 3) == 0) ? 4'd12 : 4'($urandom_range(1, 12));
        last = month_days(mo, y);
        return date_fields(y, mo,
                           $urandom_range(0, 1) ? last : 5'($urandom_range(1, last)),
                           ($urandom_range(0, 2) != 0) ? 5'd23 : 5'($urandom_range(0, 23)),
                           ($urandom_range(0, 2) != 0) ? 6'd59 : 6'($urandom_range(0, 59)),
                           $urandom_range(0, 1) ? 6'($urandom_range(50, 59))
                                                : 6'($urandom_range(0, 59)));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("calendar_second_counter_top: mismatch");
            $finish;
        end
    end

    // Sender: predicts on every accepted item, then offers the next queued
    // item after its own random gap. Valid is only dropped while waiting or with the queue empty.
    always @(posedge clk)
    begin : drive_items
        calendar_cmd_t cmd;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_readings.push_back(
                    step_calendar(csc_pkg::op_t'(s_axis_tuser),
                                  csc_pkg::in_data_t'(s_axis_tdata)));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd = pending_cmds.pop_front();
                    s_axis_tuser  <= cmd.op;
                    s_axis_tdata  <= cmd.data;
                    s_axis_tvalid <= 1'b1;
                    // alternate between gappy stretches and back-to-back runs
                    if ($urandom_range(0, 47) == 0)
                        send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest reading,
    // then stalls tready for a random number of cycles.
    always @(posedge clk)
    begin : collect_results
        clock_reading_t     want;
        csc_pkg::out_data_t got;
        csc_pkg::out_user_t flags;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got   = csc_pkg::out_data_t'(m_axis_tdata);
                flags = csc_pkg::out_user_t'(m_axis_tuser);
                results_seen++;
                if (expected_readings.size() == 0)
                begin
                    $error("result arrived with no reading pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("cur_year", 32'(want.year), 32'(got.year));
                    check_field("cur_month", 32'(want.month), 32'(got.month));
                    check_field("cur_day", 32'(want.day), 32'(got.day));
                    check_field("cur_hours", 32'(want.hours), 32'(got.hours));
                    check_field("cur_minutes", 32'(want.minutes), 32'(got.minutes));
                    check_field("cur_seconds", 32'(want.seconds), 32'(got.seconds));
                    check_field("packed_time", want.packed_time, got.packed_time);
                    check_field("load_rejected", 32'(want.load_rejected),
                                32'(flags.load_rejected));
                    check_field("day_rolled", 32'(want.day_rolled), 32'(flags.day_rolled));
                end
                if ($urandom_range(0, 47) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
            end
            if (recv_wait != 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : run_test
        csc_pkg::in_data_t d;
        logic [4:0]        last;
        int unsigned       pick;

        // Directed: a tick from the reset time, then the field extremes,
        // each rejection reason, leap and non-leap February, and carries
        // into the next day, month and year, including across year 63/64
        // (packed time saturates) and past 99.
        queue_ticks(1);
        queue_load(date_fields(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
        queue_load(date_fields(8'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd63, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd100, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30));
        queue_load(date_fields(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
        queue_load(date_fields(8'd20, 4'd0, 5'd10, 5'd10, 6'd10, 6'd10));
        queue_load(date_fields(8'd20, 4'd13, 5'd10, 5'd10, 6'd10, 6'd10));
        queue_load(date_fields(8'd20, 4'd3, 5'd0, 5'd10, 6'd10, 6'd10));
        queue_load(date_fields(8'd20, 4'd4, 5'd31, 5'd10, 6'd10, 6'd10));
        queue_load(date_fields(8'd20, 4'd5, 5'd5, 5'd24, 6'd10, 6'd10));
        queue_load(date_fields(8'd20, 4'd5, 5'd5, 5'd10, 6'd60, 6'd10));
        queue_load(date_fields(8'd20, 4'd5, 5'd5, 5'd10, 6'd10, 6'd60));
        queue_load(date_fields(8'd5, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0));
        queue_load(date_fields(8'd4, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd5, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd96, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd10, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59));
        queue_ticks(1);
        queue_load(date_fields(8'd10, 4'd6, 5'd15, 5'd12, 6'd59, 6'd59));
        queue_ticks(1);

        // Random: mostly valid loads near a boundary followed by a run of
        // ticks, with noise loads, loads broken in one field, and long
        // tick runs mixed in.
        while (pending_cmds.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                queue_load(near_boundary());
                queue_ticks($urandom_range(1, 16));
            end
            else if (pick <= 7)
            begin
                d     = csc_pkg::in_data_t'(40'({$urandom, $urandom}));
                d.pad = '0;
                queue_load(d);
            end
            else if (pick == 8)
            begin
                d    = near_boundary();
                last = month_days(d.month, d.year);
                case ($urandom_range(0, 5))
                    0: d.year    = 8'($urandom_range(100, 255));
                    1: d.month   = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                    2: d.day     = (last == 5'd31) ? 5'd0 : 5'($urandom_range(last + 1, 31));
                    3: d.hours   = 5'($urandom_range(24, 31));
                    4: d.minutes = 6'($urandom_range(60, 63));
                    default: d.seconds = 6'($urandom_range(60, 63));
                endcase
                queue_load(d);
                queue_ticks($urandom_range(0, 3));
            end
            else
            begin
                queue_ticks($urandom_range(1, 20));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // every item accepted, then every reading delivered
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d ticks (%0d midnight crossings), %0d loads taken, %0d refused",
                 ticks_sent, midnights, loads_taken, loads_refused);
        $display("%0d results checked, %0d with a year too large to pack",
                 results_seen, unpackable_years);
        if (fail_count == 0)
        begin
            $display("calendar_second_counter_top: match");
        end
        else
        begin
            $display("calendar_second_counter_top: mismatch");
        end
        $finish;
    end

endmodule
